// ===== src/pdb_pkg.sv =====
// Shared types, codes and the pixel conversion function for the decimating BGR24 converter.
package pdb_pkg;

	localparam int CntW = 14;
	localparam int FmtW = 3;

	// Configuration register indexes
	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_FORMAT = 2'd2;

	// Source pixel format codes
	localparam logic [FmtW-1:0] FMT_NONE   = 3'd0;
	localparam logic [FmtW-1:0] FMT_RAW_A  = 3'd1;
	localparam logic [FmtW-1:0] FMT_RAW_B  = 3'd2;
	localparam logic [FmtW-1:0] FMT_RAW_C  = 3'd3;
	localparam logic [FmtW-1:0] FMT_RGB565 = 3'd4;
	localparam logic [FmtW-1:0] FMT_SWAP   = 3'd5;
	localparam logic [FmtW-1:0] FMT_RGB555 = 3'd6;
	localparam logic [FmtW-1:0] FMT_RGB444 = 3'd7;

	typedef struct packed {
		logic       ok;
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} bgr_t;

	// Position status from the raster tracker
	typedef struct packed {
		logic keep;
		logic last;
	} pos_t;

	function automatic bgr_t pdb_convert(input logic [31:0] word, input logic [FmtW-1:0] fmt);
		bgr_t r;
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b2;
		logic [15:0] v;
		b0 = word[7:0];
		b1 = word[15:8];
		b2 = word[23:16];
		v = {b1, b0};
		r = '0;
		case (fmt) inside
			FMT_RAW_A, FMT_RAW_B, FMT_RAW_C: begin
				r = {1'b1, b0, b1, b2};
			end
			FMT_SWAP: begin
				r = {1'b1, b2, b1, b0};
			end
			FMT_RGB565: begin
				r = {1'b1, 3'b000, v[4:0], 2'b00, v[10:5], 3'b000, v[15:11]};
			end
			FMT_RGB555: begin
				r = {1'b1, 3'b000, v[4:0], 3'b000, v[9:5], 3'b000, v[14:10]};
			end
			FMT_RGB444: begin
				r = {1'b1, 4'h0, v[3:0], 4'h0, v[7:4], 4'h0, v[11:8]};
			end
			default: begin
				r = '0;
			end
		endcase
		return r;
	endfunction

endpackage

// ===== src/pdb_cfg_regs.sv =====
// APB register file: frame width, frame height and pixel format.
module pdb_cfg_regs
	import pdb_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            psel,
	input  logic            penable,
	input  logic            pwrite,
	input  logic [3:0]      paddr,
	input  logic [31:0]     pwdata,
	output logic [31:0]     prdata,
	output logic            pready,
	output logic [CntW-1:0] frame_width,
	output logic [CntW-1:0] frame_height,
	output logic [FmtW-1:0] pixel_format
);

	logic [CntW-1:0] width_q;
	logic [CntW-1:0] height_q;
	logic [FmtW-1:0] format_q;
	logic            wr_en;
	logic [1:0]      idx;

	assign pready = 1'b1;
	assign idx    = paddr[3:2];
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= '0;
			height_q <= '0;
			format_q <= FMT_NONE;
		end else if (wr_en) begin
			unique case (idx)
				REG_WIDTH:  width_q  <= pwdata[CntW-1:0];
				REG_HEIGHT: height_q <= pwdata[CntW-1:0];
				REG_FORMAT: format_q <= pwdata[FmtW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_WIDTH:  prdata = {{(32-CntW){1'b0}}, width_q};
			REG_HEIGHT: prdata = {{(32-CntW){1'b0}}, height_q};
			REG_FORMAT: prdata = {{(32-FmtW){1'b0}}, format_q};
			default:    prdata = '0;
		endcase
	end

	assign frame_width  = width_q;
	assign frame_height = height_q;
	assign pixel_format = format_q;

endmodule

// ===== src/pdb_tracker.sv =====
// Raster position counters; flag kept (even row, even column) pixels and the frame's last one.
module pdb_tracker
	import pdb_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            step,
	input  logic [CntW-1:0] frame_width,
	input  logic [CntW-1:0] frame_height,
	output pos_t            pos
);

	logic [CntW-1:0] col_q;
	logic [CntW-1:0] row_q;
	logic [CntW-1:0] w;
	logic [CntW-1:0] h;
	logic            empty;
	logic [CntW:0]   col_nx;
	logic [CntW:0]   row_nx;

	assign w      = {frame_width[CntW-1:1], 1'b0};
	assign h      = {frame_height[CntW-1:1], 1'b0};
	assign empty  = (w == '0) || (h == '0);
	assign col_nx = {1'b0, col_q} + {{CntW{1'b0}}, 1'b1};
	assign row_nx = {1'b0, row_q} + {{CntW{1'b0}}, 1'b1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (step) begin
			if (empty) begin
				col_q <= '0;
				row_q <= '0;
			end else if (col_nx >= {1'b0, w}) begin
				col_q <= '0;
				row_q <= (row_nx >= {1'b0, h}) ? '0 : row_nx[CntW-1:0];
			end else begin
				col_q <= col_nx[CntW-1:0];
			end
		end
	end

	assign pos.keep = !empty && !col_q[0] && !row_q[0];
	assign pos.last = (col_q == w - CntW'(2)) && (row_q == h - CntW'(2));

	always_ff @(posedge clk) begin
		if (arst_n && pos.keep && !(col_q[0] == 1'b0 && row_q[0] == 1'b0))
			$error("kept pixel at odd position");
	end

	a_empty_clears: assert property (@(posedge clk) disable iff (!arst_n)
		step && empty |=> col_q == '0 && row_q == '0)
		else $error("counters not cleared on empty frame");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!step |=> $stable(col_q) && $stable(row_q))
		else $error("counters moved without a pixel");

	a_col_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		step && !empty && col_nx >= {1'b0, w} |=> col_q == '0)
		else $error("column did not wrap");

endmodule

// ===== src/pixel_decimate_to_bgr24_top.sv =====
// Top level: APB registers, input register stage, raster tracker and BGR24 result register.
// An accepted pixel goes through the input register, then the result register.
// Throughput: one pixel per cycle unless m_tready stalls the two registers (input, result).
// Decimated and unknown-format pixels drop out after the input stage and give no result.
// Reset (arst_n low, asynchronous): pipeline empty, counters zero, registers zero.
module pixel_decimate_to_bgr24_top
	import pdb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// APB configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// pixel input
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,    // [31:0] pixel_word
	// BGR24 output
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,    // [7:0] blue_byte, [15:8] green_byte, [23:16] red_byte
	output logic        m_tlast     // frame_end
);

	logic [CntW-1:0] frame_width;
	logic [CntW-1:0] frame_height;
	logic [FmtW-1:0] pixel_format;

	logic        valid_s1;
	logic [31:0] pixel_s1;
	logic        valid_s2;
	logic [23:0] bgr_s2;
	logic        last_s2;
	logic        advance;
	logic        step;
	pos_t        pos;
	bgr_t        conv;
	logic        emit;

	pdb_cfg_regs u_regs (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.frame_width  (frame_width),
		.frame_height (frame_height),
		.pixel_format (pixel_format)
	);

	// The pipeline moves when the result register is free or being drained
	assign advance  = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || advance;
	assign step     = valid_s1 && advance;

	pdb_tracker u_tracker (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (step),
		.frame_width  (frame_width),
		.frame_height (frame_height),
		.pos          (pos)
	);

	assign conv = pdb_convert(pixel_s1, pixel_format);
	assign emit = pos.keep && conv.ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid)
			pixel_s1 <= s_tdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1 && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (step && emit) begin
			bgr_s2  <= {conv.red, conv.green, conv.blue};
			last_s2 <= pos.last;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = bgr_s2;
	assign m_tlast  = last_s2;

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(pixel_s1))
		else $error("input stage lost a pixel under stall");

	a_no_fmt: assert property (@(posedge clk) disable iff (!arst_n)
		step && !conv.ok |=> !m_tvalid)
		else $error("result produced for unknown format");

	a_drop: assert property (@(posedge clk) disable iff (!arst_n)
		step && !pos.keep |=> !m_tvalid)
		else $error("result produced for decimated pixel");

	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> s_tready)
		else $error("input stalled with empty input stage");

endmodule

// ===== sim/tb_pixel_decimate_to_bgr24_top.sv =====
// Testbench for the decimating BGR24 converter: random frames checked against a predictor.
module tb_pixel_decimate_to_bgr24_top
	import pdb_pkg::*;
();

	localparam int RUN_ITEMS   = 1750;
	localparam int CYCLE_LIMIT = 200000;
	localparam int PIPE_DELAY  = 4;

	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
		logic       frame_end;
	} bgr_px_t;

	class bgr_scoreboard;
		logic [CntW-1:0] width;
		logic [CntW-1:0] height;
		logic [FmtW-1:0] fmt;
		int col;
		int row;
		bgr_px_t expected_q[$];
		int mismatches;

		function new();
			width = '0;
			height = '0;
			fmt = FMT_NONE;
			col = 0;
			row = 0;
			mismatches = 0;
		endfunction

		function void set_reg(input logic [1:0] idx, input logic [31:0] val);
			case (idx)
				REG_WIDTH: begin
					width = val[CntW-1:0];
				end
				REG_HEIGHT: begin
					height = val[CntW-1:0];
				end
				REG_FORMAT: begin
					fmt = val[FmtW-1:0];
				end
				default: begin
				end
			endcase
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		// Advance the raster position and queue the BGR bytes of a kept pixel.
		function void note_pixel(input logic [31:0] word);
			int w;
			int h;
			logic [15:0] v;
			logic hit;
			bgr_px_t e;
			w = int'({width[CntW-1:1], 1'b0});
			h = int'({height[CntW-1:1], 1'b0});
			if (w == 0 || h == 0) begin
				col = 0;
				row = 0;
				return;
			end
			v = word[15:0];
			hit = 1'b1;
			e = '0;
			case (fmt)
				FMT_RAW_A, FMT_RAW_B, FMT_RAW_C: begin
					e.blue = word[7:0];
					e.green = word[15:8];
					e.red = word[23:16];
				end
				FMT_SWAP: begin
					e.blue = word[23:16];
					e.green = word[15:8];
					e.red = word[7:0];
				end
				FMT_RGB565: begin
					e.blue = {3'b000, v[4:0]};
					e.green = {2'b00, v[10:5]};
					e.red = {3'b000, v[15:11]};
				end
				FMT_RGB555: begin
					e.blue = {3'b000, v[4:0]};
					e.green = {3'b000, v[9:5]};
					e.red = {3'b000, v[14:10]};
				end
				FMT_RGB444: begin
					e.blue = {4'h0, v[3:0]};
					e.green = {4'h0, v[7:4]};
					e.red = {4'h0, v[11:8]};
				end
				default: begin
					hit = 1'b0;
				end
			endcase
			if (hit && col % 2 == 0 && row % 2 == 0) begin
				e.frame_end = (col == w - 2) && (row == h - 2);
				expected_q.push_back(e);
			end
			// position may sit past the frame after a size change
			col = col + 1;
			if (col >= w) begin
				col = 0;
				row = row + 1;
				if (row >= h)
					row = 0;
			end
		endfunction

		function void check_bgr(input logic [23:0] data, input logic last);
			bgr_px_t e;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: bgr=%06h last=%0b", data, last);
				return;
			end
			e = expected_q.pop_front();
			if (data[7:0] !== e.blue || data[15:8] !== e.green || data[23:16] !== e.red ||
					last !== e.frame_end) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: blue %02h/%02h green %02h/%02h red %02h/%02h last %0b/%0b",
						e.blue, data[7:0], e.green, data[15:8], e.red, data[23:16],
						e.frame_end, last);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;    // [31:0] pixel_word
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;    // [7:0] blue_byte, [15:8] green_byte, [23:16] red_byte
	logic        m_tlast;    // frame_end

	bgr_scoreboard sb;
	bit calm;
	int cycles;

	pixel_decimate_to_bgr24_top i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(negedge clk) begin
		m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 17);
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_bgr(m_tdata, m_tlast);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		sb.set_reg(idx, val);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic configure(input int w, input int h, input logic [FmtW-1:0] f);
		write_reg(REG_WIDTH, 32'(w));
		write_reg(REG_HEIGHT, 32'(h));
		write_reg(REG_FORMAT, 32'(f));
	endtask

	task automatic send_pixel(input logic [31:0] word);
		@(negedge clk);
		while (!calm && $urandom_range(99) < 17) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= word;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_pixel(word);
	endtask

	// Hold the sender until every queued result is out, then let the pipeline settle.
	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (PIPE_DELAY) @(posedge clk);
	endtask

	function automatic int pick_size();
		int r;
		r = $urandom_range(99);
		if (r < 8)
			return $urandom_range(0, 1);
		if (r < 16)
			return $urandom_range(16382, 16383);
		if (r < 26)
			return $urandom_range(0, 16383);
		return $urandom_range(2, 12);
	endfunction

	initial begin
		logic [FmtW-1:0] dir_fmt[6];
		logic [31:0] dir_word[6];
		int sent;
		int calm_from;
		int w;
		int h;
		int n;
		logic [FmtW-1:0] f;

		sb = new();
		calm = 1'b0;
		cycles = 0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		// registers still zero: empty frame, pixels dropped
		send_pixel(32'hFFFF_FFFF);
		send_pixel(32'h0000_0000);
		drain();

		// 2x2 frame: one kept pixel per frame, always the frame end
		dir_fmt = '{FMT_RAW_A, FMT_RGB565, FMT_SWAP, FMT_RGB555, FMT_RGB444, FMT_NONE};
		dir_word = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h00A5_5A0F, 32'hFFFF_7FFF,
			32'hFF00_0FFF, 32'h1234_5678};
		for (int i = 0; i < 6; i++) begin
			configure(3, 2, dir_fmt[i]);
			send_pixel(dir_word[i]);
			send_pixel(32'hFFFF_FFFF);
			send_pixel(32'h0000_0000);
			send_pixel(~dir_word[i]);
			drain();
		end

		// widest frame, then shrink it under the running counters
		configure(16383, 16383, FMT_RGB444);
		send_pixel(32'h0000_0FFF);
		send_pixel(32'hFFFF_FFFF);
		send_pixel(32'h0000_0ABC);
		drain();

		sent = 0;
		calm_from = $urandom_range(500, 1000);
		while (sent < RUN_ITEMS) begin
			w = pick_size();
			h = pick_size();
			f = FmtW'($urandom_range(0, 7));
			configure(w, h, f);
			if (w < 2 || h < 2) begin
				n = $urandom_range(1, 4);
				for (int k = 0; k < n; k++)
					send_pixel($urandom);
			end else begin
				n = $urandom_range(1, 120);
				for (int k = 0; k < n; k++) begin
					calm = (sent >= calm_from) && (sent < calm_from + 300);
					send_pixel($urandom);
					sent++;
				end
			end
			drain();
		end
		calm = 1'b0;

		drain();
		repeat (8) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
